// ===== hdl/rpba_pkg.sv =====
package rpba_pkg;

    localparam int DEF_MAX_PAGES   = 16;
    localparam int DEF_QUEUE_DEPTH = 32;
    localparam logic [31:0] MIN_PAGE_RESET = 32'd65536;

    localparam logic [1:0] KIND_ALLOC    = 2'd0;
    localparam logic [1:0] KIND_SUBMIT   = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SLOT  = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_Q_FULL   = 3'd3;
    localparam logic [2:0] ST_TOO_BIG  = 3'd4;

    // result item as presented on the master side
    typedef struct packed {
        logic [5:0]  released_count;
        logic [47:0] fence_value;
        logic [31:0] data_offset;
        logic [31:0] offset_in_page;
        logic [3:0]  chosen_page;
        logic [2:0]  status;
    } rpba_result_t;

endpackage

// ===== hdl/refcounted_page_bump_allocator_core.sv =====
// Staging-page sub-allocator. A request on the s_ side carries kind in tuser
// (0 allocate, 1 submit, 2 completion) and takes one result on the m_ side.
// Requests are handled one at a time by a small sequencer around one shared
// subtract/compare unit. An allocate request walks the open pages one per
// cycle (best fit, ties to the lowest page), then places and aligns the
// allocation and presents its result. A request that is too large answers
// from the scan, and one that finds no free slot answers from placement
// without aligning. A completion retires queue entries one at a time, each
// through a read, a compare and a drop, the queue being held in a
// registered-read RAM. s_tready is high only while the sequencer is idle and
// the result register is free, so the next request is accepted only after
// the result has been taken. No clearing pass is needed after reset.
module refcounted_page_bump_allocator_core import rpba_pkg::*; #(
    parameter int MAX_PAGES   = DEF_MAX_PAGES,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: alloc_size[31:0], align_log2[36:32], page_id[40:37],
    //        completed_fence[88:41], zero fill [95:89]
    input  logic [95:0]  s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[2:0], chosen_page[6:3], offset_in_page[38:7],
    //        data_offset[70:39], fence_value[118:71], released_count[124:119],
    //        zero fill [127:125]
    output logic [127:0] m_tdata
);

    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int OW = $clog2(MAX_PAGES + 1);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_PLACE  = 4'd2;
    localparam logic [3:0] S_ALIGN  = 4'd3;
    localparam logic [3:0] S_SUBMIT = 4'd4;
    localparam logic [3:0] S_QRD    = 4'd5;
    localparam logic [3:0] S_QCMP   = 4'd6;
    localparam logic [3:0] S_QDROP  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [31:0] min_page_reg;
    logic [OW-1:0] pages_open_reg;
    logic [47:0] last_fence_reg;
    logic [QW-1:0] head_reg;
    logic [CW-1:0] count_reg;

    logic [1:0]  kind_reg;
    logic [31:0] size_reg;
    logic [4:0]  alog_reg;
    logic [3:0]  pid_reg;
    logic [47:0] done_reg;
    logic [32:0] need_reg;
    logic [OW-1:0] idx_reg;
    logic        found_reg;
    logic [PW-1:0] best_reg;
    logic [31:0] best_rem_reg;
    logic [31:0] start_reg;
    logic [5:0]  rel_reg;

    logic [31:0] cap_reg  [MAX_PAGES];
    logic [31:0] fill_reg [MAX_PAGES];
    logic [15:0] refs_reg [MAX_PAGES];

    rpba_result_t res_reg;
    logic         m_valid_reg;

    // queue RAM: {page, fence}
    logic          q_we;
    logic [QW-1:0] q_waddr, q_raddr;
    logic [51:0]   q_wdata, q_rdata;

    rpba_ram #(.WIDTH(52), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk (aclk), .we (q_we), .waddr (q_waddr), .wdata (q_wdata),
        .raddr (q_raddr), .rdata (q_rdata)
    );

    logic in_fire;
    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, res_reg};

    // shared unit: remaining space of the page under the scan index
    logic [PW-1:0] scan_p;
    logic [31:0]   rem;
    logic          fits;
    logic [31:0]   align_m1;
    logic [32:0]   aligned;
    assign scan_p   = idx_reg[PW-1:0];
    assign rem      = cap_reg[scan_p] - fill_reg[scan_p];
    assign fits     = {1'b0, rem} >= need_reg;
    assign align_m1 = 32'((33'd1 << alog_reg) - 33'd1);
    assign aligned  = ({1'b0, start_reg} + {1'b0, align_m1}) & ~{1'b0, align_m1};

    // queue tail: head plus count, wrapped once
    logic [CW:0]   tail_sum;
    logic [QW-1:0] tail;
    logic          pid_known;
    assign tail_sum  = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign tail      = (tail_sum >= (CW+1)'(QUEUE_DEPTH))
                       ? QW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    assign pid_known = (32'(pid_reg) < 32'(pages_open_reg));
    assign q_raddr = head_reg;
    assign q_we    = (state_reg == S_SUBMIT) && pid_known &&
                     (count_reg < CW'(QUEUE_DEPTH));
    assign q_waddr = tail;
    assign q_wdata = {pid_reg, 48'(last_fence_reg + 48'd1)};

    logic [PW-1:0] qpage;
    assign qpage = PW'(q_rdata[51:48]);

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_fire) begin
                unique case (s_tuser)
                    KIND_ALLOC:    state_next = S_SCAN;
                    KIND_SUBMIT:   state_next = S_SUBMIT;
                    KIND_COMPLETE: state_next = S_QRD;
                    default:       state_next = S_DONE;
                endcase
            end
            S_SCAN:   if (need_reg[32]) state_next = S_DONE;
                      else if (idx_reg >= pages_open_reg) state_next = S_PLACE;
            S_PLACE:  state_next = (!found_reg && pages_open_reg >= OW'(MAX_PAGES))
                                   ? S_DONE : S_ALIGN;
            S_ALIGN:  state_next = S_DONE;
            S_SUBMIT: state_next = S_DONE;
            S_QRD:    state_next = (count_reg == '0) ? S_DONE : S_QCMP;
            S_QCMP:   state_next = (q_rdata[47:0] > done_reg) ? S_DONE : S_QDROP;
            S_QDROP:  state_next = S_QRD;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            min_page_reg   <= MIN_PAGE_RESET;
            pages_open_reg <= '0;
            last_fence_reg <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                min_page_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: if (in_fire) begin
                    kind_reg  <= s_tuser;
                    size_reg  <= s_tdata[31:0];
                    alog_reg  <= s_tdata[36:32];
                    pid_reg   <= s_tdata[40:37];
                    done_reg  <= s_tdata[88:41];
                    need_reg  <= {1'b0, s_tdata[31:0]} + 33'((33'd1 << s_tdata[36:32]) - 33'd1);
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    rel_reg   <= '0;
                    res_reg   <= '0;
                end
                S_SCAN: begin
                    // walk one open page per cycle, keep the tightest fit
                    if (need_reg[32]) begin
                        res_reg.status <= ST_TOO_BIG;
                    end else if (idx_reg < pages_open_reg) begin
                        if (fits && (!found_reg || rem < best_rem_reg)) begin
                            found_reg    <= 1'b1;
                            best_reg     <= scan_p;
                            best_rem_reg <= rem;
                        end
                        idx_reg <= idx_reg + OW'(1);
                    end
                end
                S_PLACE: begin
                    if (found_reg) begin
                        start_reg <= fill_reg[best_reg];
                    end else if (pages_open_reg >= OW'(MAX_PAGES)) begin
                        res_reg.status <= ST_NO_SLOT;
                    end else begin
                        // open a fresh page
                        best_reg <= PW'(pages_open_reg);
                        cap_reg[PW'(pages_open_reg)] <=
                            (need_reg[31:0] > min_page_reg) ? need_reg[31:0] : min_page_reg;
                        refs_reg[PW'(pages_open_reg)] <= '0;
                        start_reg <= '0;
                        pages_open_reg <= pages_open_reg + OW'(1);
                    end
                end
                S_ALIGN: begin
                    fill_reg[best_reg] <= aligned[31:0] + size_reg;
                    if (refs_reg[best_reg] != 16'hFFFF) begin
                        refs_reg[best_reg] <= refs_reg[best_reg] + 16'd1;
                    end
                    res_reg.chosen_page    <= 4'(best_reg);
                    res_reg.offset_in_page <= start_reg;
                    res_reg.data_offset    <= aligned[31:0];
                end
                S_SUBMIT: begin
                    if (!pid_known) begin
                        res_reg.status <= ST_UNKNOWN;
                    end else if (!q_we) begin
                        res_reg.status <= ST_Q_FULL;
                    end else begin
                        last_fence_reg       <= last_fence_reg + 48'd1;
                        count_reg            <= count_reg + CW'(1);
                        res_reg.fence_value  <= last_fence_reg + 48'd1;
                    end
                end
                S_QRD: ;
                S_QCMP: ;
                S_QDROP: begin
                    // retire the head entry and drop its page reference
                    if ({1'b0, qpage} < (PW+1)'(pages_open_reg) &&
                            refs_reg[qpage] != '0) begin
                        refs_reg[qpage] <= refs_reg[qpage] - 16'd1;
                        if (refs_reg[qpage] == 16'd1) begin
                            fill_reg[qpage] <= '0;
                        end
                    end
                    head_reg  <= (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                    : head_reg + QW'(1);
                    count_reg <= count_reg - CW'(1);
                    rel_reg   <= rel_reg + 6'd1;
                end
                S_DONE: begin
                    if (kind_reg == KIND_COMPLETE) begin
                        res_reg.released_count <= rel_reg;
                    end
                    m_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_open_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pages_open_reg <= OW'(MAX_PAGES)) else $error("pages_open overflow");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == S_IDLE && !m_tvalid)) else $error("ready while busy");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |=> m_tvalid) else $error("result lost");
`endif

endmodule

// ===== hdl/rpba_ram.sv =====
module rpba_ram import rpba_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one entry, register the read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
